### sv/cnc_pkg.sv
// Shared types and constants for the coverage novelty check block.
package cnc_pkg;

  localparam int WORD_W = 64;
  localparam int IDX_W  = 13;
  localparam int BYTE_W = 8;
  localparam int LANES  = WORD_W / BYTE_W;

  localparam logic ACT_CHECK = 1'b0;
  localparam logic ACT_LOAD  = 1'b1;

  localparam logic [1:0] VERD_NONE  = 2'd0;
  localparam logic [1:0] VERD_HITS  = 2'd1;
  localparam logic [1:0] VERD_BYTES = 2'd2;

  localparam logic [WORD_W-1:0] WORD_ONES = {WORD_W{1'b1}};
  localparam logic [BYTE_W-1:0] BYTE_ONES = {BYTE_W{1'b1}};

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK
  } state_e;

  typedef struct packed {
    logic hit;
    logic fresh;
    logic ones;
  } lane_res_t;

endpackage

### sv/cnc_ram.sv
// Generic single write port, single read port RAM with registered read data.
module cnc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### sv/cnc_lane.sv
// One byte lane: compares a coverage byte with its virgin byte.
module cnc_lane (
  input  logic [cnc_pkg::BYTE_W-1:0] cov_i,
  input  logic [cnc_pkg::BYTE_W-1:0] vir_i,
  output cnc_pkg::lane_res_t         res_o,
  output logic [cnc_pkg::BYTE_W-1:0] vir_new_o
);
  import cnc_pkg::*;

  always_comb begin
    res_o.hit   = |(cov_i & vir_i);
    res_o.ones  = (vir_i == BYTE_ONES);
    res_o.fresh = (cov_i != '0) && (vir_i == BYTE_ONES);
    vir_new_o   = vir_i & ~cov_i;
  end

endmodule

### sv/cnc_merge.sv
// Merges the lane results into the updated running verdict and write enable.
module cnc_merge (
  input  cnc_pkg::lane_res_t [cnc_pkg::LANES-1:0] res_i,
  input  logic                                    in_range_i,
  input  logic [1:0]                              verdict_i,
  output logic                                    wr_o,
  output logic [1:0]                              verdict_o
);
  import cnc_pkg::*;

  logic             any_hit;
  logic             any_fresh;
  logic             all_ones;
  logic [1:0]       level;

  always_comb begin
    any_hit   = 1'b0;
    any_fresh = 1'b0;
    all_ones  = 1'b1;
    for (int k = 0; k < LANES; k++) begin
      any_hit   = any_hit | res_i[k].hit;
      any_fresh = any_fresh | res_i[k].fresh;
      all_ones  = all_ones & res_i[k].ones;
    end
    level = (all_ones || any_fresh) ? VERD_BYTES : VERD_HITS;
    wr_o  = in_range_i && any_hit;
    if (wr_o && (level > verdict_i)) begin
      verdict_o = level;
    end else begin
      verdict_o = verdict_i;
    end
  end

endmodule

### sv/coverage_novelty_check_top.sv
// Top level of the coverage novelty check block with the virgin map memory.
// A check item with last reads the map word, is compared in the compare state, and its verdict is then registered.
// A check item is a memory read, then a compare and write back; no new item is taken during the compare.
// A load item's write goes straight into the virgin map memory, and the block stays idle for the next item.
// After reset a clearing pass writes all ones to every map word, with no item taken.
// The running verdict and the output register are cleared at reset.
module coverage_novelty_check_top #(
  parameter int MAP_WORDS = 8192
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       action_i,
  input  logic [cnc_pkg::IDX_W-1:0]  word_index_i,
  input  logic [cnc_pkg::WORD_W-1:0] map_word_i,
  input  logic                       last_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 verdict_o
);
  import cnc_pkg::*;

  localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int XW = (AW > IDX_W) ? AW : IDX_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_WORDS - 1);

  state_e state_q, state_d;

  logic [AW-1:0]     clr_q, clr_d;
  logic [AW-1:0]     addr_q;
  logic [WORD_W-1:0] cov_q;
  logic              last_q;
  logic              range_q;
  logic [1:0]        verdict_q, verdict_d;
  logic              out_valid_q, out_valid_d;
  logic [1:0]        out_verdict_q, out_verdict_d;

  logic [XW-1:0]     idx_x;
  logic [AW-1:0]     in_addr;
  logic              in_range;
  logic              accept;
  logic              clr_done;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [WORD_W-1:0] wdata;
  logic [WORD_W-1:0] vir;
  logic [WORD_W-1:0] vir_new;

  lane_res_t [LANES-1:0] lane_res;
  logic              merge_wr;
  logic [1:0]        merge_verdict;

  assign idx_x    = XW'(word_index_i);
  assign in_addr  = idx_x[AW-1:0];
  assign in_range = (32'(word_index_i) < MAP_WORDS);
  assign accept   = in_valid_i && !in_stall_o;
  assign clr_done = (clr_q == LAST_ADDR);

  cnc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAP_WORDS),
    .AW    (AW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (in_addr),
    .rdata_o (vir)
  );

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    cnc_lane u_lane (
      .cov_i     (cov_q[g*BYTE_W +: BYTE_W]),
      .vir_i     (vir[g*BYTE_W +: BYTE_W]),
      .res_o     (lane_res[g]),
      .vir_new_o (vir_new[g*BYTE_W +: BYTE_W])
    );
  end

  cnc_merge u_merge (
    .res_i      (lane_res),
    .in_range_i (range_q),
    .verdict_i  (verdict_q),
    .wr_o       (merge_wr),
    .verdict_o  (merge_verdict)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && (action_i == ACT_CHECK)) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall_o    = 1'b1;
    we            = 1'b0;
    waddr         = addr_q;
    wdata         = vir_new;
    clr_d         = clr_q;
    verdict_d     = verdict_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_verdict_d = out_verdict_q;
    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = WORD_ONES;
        clr_d = clr_q + AW'(1);
      end
      ST_IDLE: begin
        in_stall_o = out_valid_q && out_stall_i && (action_i == ACT_CHECK) && last_i;
        we         = accept && (action_i == ACT_LOAD) && in_range;
        waddr      = in_addr;
        wdata      = map_word_i;
      end
      ST_CHECK: begin
        we        = merge_wr;
        verdict_d = merge_verdict;
        if (last_q) begin
          out_valid_d   = 1'b1;
          out_verdict_d = merge_verdict;
          verdict_d     = VERD_NONE;
        end
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_q         <= '0;
      verdict_q     <= VERD_NONE;
      out_valid_q   <= 1'b0;
      out_verdict_q <= VERD_NONE;
    end else begin
      state_q       <= state_d;
      clr_q         <= clr_d;
      verdict_q     <= verdict_d;
      out_valid_q   <= out_valid_d;
      out_verdict_q <= out_verdict_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q  <= in_addr;
      cov_q   <= map_word_i;
      last_q  <= last_i;
      range_q <= in_range;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = out_verdict_q;

`ifndef SYNTHESIS
  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> in_stall_o)
    else $error("Item taken during the clearing pass.");

  a_check_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (action_i == ACT_CHECK)) |=> (state_q == ST_CHECK))
    else $error("Check item did not start its compare cycle.");

  a_check_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK) |=> (state_q == ST_IDLE))
    else $error("Compare cycle did not return to idle.");

  a_verdict_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (verdict_o != 2'd3))
    else $error("Verdict out of range.");

  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_CHECK) && last_q) |=> (out_valid_o && (verdict_q == VERD_NONE)))
    else $error("Last check item did not give a verdict.");
`endif

endmodule

### test/tb_top.sv
// Self-checking testbench for the coverage novelty check block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cnc_pkg::*;

  localparam int MAP_N        = 8192;
  localparam int RANDOM_ITEMS = 950;
  localparam int HOT_N        = 16;
  localparam int ROWS         = 25;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PATTERN
  } stall_mode_e;

  typedef struct packed {
    logic              act;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] word;
    logic              last;
    logic              typed;
    logic [1:0]        verdict;
  } dir_row_t;

  localparam dir_row_t DIRECTED [ROWS] = '{
    '{ACT_CHECK, 13'd0,    64'h0,                  1'b1, 1'b1, VERD_NONE},
    '{ACT_CHECK, 13'd0,    64'h1,                  1'b1, 1'b1, VERD_BYTES},
    '{ACT_CHECK, 13'd0,    64'h2,                  1'b1, 1'b1, VERD_HITS},
    '{ACT_CHECK, 13'd0,    64'h2,                  1'b1, 1'b1, VERD_NONE},
    '{ACT_CHECK, 13'd0,    64'h100,                1'b1, 1'b1, VERD_BYTES},
    '{ACT_CHECK, 13'd1,    64'h1,                  1'b0, 1'b0, VERD_NONE},
    '{ACT_CHECK, 13'd0,    64'h4,                  1'b1, 1'b1, VERD_BYTES},
    '{ACT_LOAD,  13'd8191, 64'h0,                  1'b1, 1'b0, VERD_NONE},
    '{ACT_CHECK, 13'd8191, WORD_ONES,              1'b1, 1'b1, VERD_NONE},
    '{ACT_LOAD,  13'd8191, WORD_ONES,              1'b0, 1'b0, VERD_NONE},
    '{ACT_CHECK, 13'd8191, WORD_ONES,              1'b1, 1'b1, VERD_BYTES},
    '{ACT_CHECK, 13'd8191, WORD_ONES,              1'b1, 1'b1, VERD_NONE},
    '{ACT_LOAD,  13'd5,    64'hfe,                 1'b0, 1'b0, VERD_NONE},
    '{ACT_CHECK, 13'd5,    64'h2,                  1'b1, 1'b1, VERD_HITS},
    '{ACT_CHECK, 13'd5,    64'hff00_0000_0000_0000, 1'b1, 1'b1, VERD_NONE},
    '{ACT_CHECK, 13'h1aaa, 64'haaaa_aaaa_aaaa_aaaa, 1'b0, 1'b0, VERD_NONE},
    '{ACT_CHECK, 13'h1555, 64'h5555_5555_5555_5555, 1'b1, 1'b1, VERD_BYTES},
    '{ACT_CHECK, 13'd2,    64'h1,                  1'b0, 1'b0, VERD_NONE},
    '{ACT_LOAD,  13'd3,    64'h0,                  1'b1, 1'b0, VERD_NONE},
    '{ACT_CHECK, 13'd3,    64'h1,                  1'b1, 1'b1, VERD_BYTES},
    '{ACT_CHECK, 13'd4,    64'h0,                  1'b0, 1'b0, VERD_NONE},
    '{ACT_CHECK, 13'd4,    64'h0,                  1'b1, 1'b1, VERD_NONE},
    '{ACT_CHECK, 13'd6,    64'h8000_0000_0000_0001, 1'b1, 1'b0, VERD_NONE},
    '{ACT_LOAD,  13'd7,    64'hff00_ff00_ff00_ff00, 1'b0, 1'b0, VERD_NONE},
    '{ACT_CHECK, 13'd7,    64'h0101_0101_0101_0101, 1'b1, 1'b0, VERD_NONE}
  };

  logic              clk_i;
  logic              rst_ni       = 1'b0;
  logic              in_valid_i   = 1'b0;
  logic              in_stall_o;
  logic              action_i     = ACT_CHECK;
  logic [IDX_W-1:0]  word_index_i = '0;
  logic [WORD_W-1:0] map_word_i   = '0;
  logic              last_i       = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i  = 1'b0;
  logic [1:0]        verdict_o;

  logic [WORD_W-1:0] virgin_copy [MAP_N];
  logic [1:0]        verdict_acc;
  logic [1:0]        verdict_q [$];
  logic [IDX_W-1:0]  hot_idx [HOT_N];

  int          errors;
  int          n_sent;
  int          n_checks;
  int          n_loads;
  int          verdict_seen [3];
  int          burst_left;
  bit          steady;
  stall_mode_e stall_mode;
  int          mode_left;
  logic [15:0] stall_pat;
  logic [1:0]  popped;

  coverage_novelty_check_top #(.MAP_WORDS(MAP_N)) DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("[coverage_novelty_check_top] ERROR");
    $finish;
  end

  task automatic score_novelty(input logic act, input logic [IDX_W-1:0] idx,
                               input logic [WORD_W-1:0] word, input logic lst,
                               output logic emits, output logic [1:0] v);
    logic [WORD_W-1:0] vir;
    logic              fresh;
    logic [1:0]        lvl;
    int                k;
    emits = 1'b0;
    v = VERD_NONE;
    if (act == ACT_LOAD) begin
      if (idx < MAP_N) virgin_copy[idx] = word;
    end else begin
      if (idx < MAP_N) begin
        vir = virgin_copy[idx];
        if ((word & vir) != '0) begin
          fresh = (vir == WORD_ONES);
          for (k = 0; k < LANES; k++) begin
            if (word[k*BYTE_W +: BYTE_W] != '0 && vir[k*BYTE_W +: BYTE_W] == BYTE_ONES) begin
              fresh = 1'b1;
            end
          end
          lvl = fresh ? VERD_BYTES : VERD_HITS;
          if (lvl > verdict_acc) verdict_acc = lvl;
          virgin_copy[idx] = vir & ~word;
        end
      end
      if (lst) begin
        emits = 1'b1;
        v = verdict_acc;
        verdict_acc = VERD_NONE;
      end
    end
  endtask

  task automatic issue_item(input logic act, input logic [IDX_W-1:0] idx,
                            input logic [WORD_W-1:0] word, input logic lst,
                            input logic typed, input logic [1:0] typed_v);
    logic       emits;
    logic [1:0] v;
    int         gap;
    in_valid_i   <= 1'b1;
    action_i     <= act;
    word_index_i <= idx;
    map_word_i   <= word;
    last_i       <= lst;
    do @(posedge clk_i); while (in_stall_o);
    score_novelty(act, idx, word, lst, emits, v);
    if (emits) verdict_q.push_back(typed ? typed_v : v);
    n_sent++;
    if (act == ACT_LOAD) n_loads++;
    else n_checks++;
    if ($urandom_range(0, 99) == 0) steady = !steady;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  function automatic logic [WORD_W-1:0] coverage_word();
    logic [WORD_W-1:0] w;
    case ($urandom_range(0, 9))
      0:       w = '0;
      1:       w = WORD_ONES;
      2, 3, 4: w = {{(WORD_W-1){1'b0}}, 1'b1} << $urandom_range(0, WORD_W-1);
      5, 6:    w = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  function automatic logic [WORD_W-1:0] virgin_word();
    logic [WORD_W-1:0] w;
    int                k;
    for (k = 0; k < LANES; k++) begin
      case ($urandom_range(0, 2))
        0:       w[k*BYTE_W +: BYTE_W] = BYTE_ONES;
        1:       w[k*BYTE_W +: BYTE_W] = '0;
        default: w[k*BYTE_W +: BYTE_W] = BYTE_W'($urandom);
      endcase
    end
    return w;
  endfunction

  function automatic logic [IDX_W-1:0] hot_pick();
    return hot_idx[$urandom_range(0, HOT_N-1)];
  endfunction

  always @(posedge clk_i) begin
    if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (verdict_q.size() == 0) begin
        $display("%0t ns: verdict with none expected: expected none, got %0d",
                 $time, verdict_o);
        errors++;
      end else begin
        popped = verdict_q.pop_front();
        if (verdict_o !== popped) begin
          $display("%0t ns: verdict mismatch: expected %0d, got %0d",
                   $time, popped, verdict_o);
          errors++;
        end
        if (verdict_o < 3) verdict_seen[verdict_o]++;
      end
    end
    if (mode_left <= 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 2));
      mode_left = $urandom_range(40, 300);
      stall_pat = 16'($urandom);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      STALL_NONE:   out_stall_i <= 1'b0;
      STALL_RANDOM: out_stall_i <= ($urandom_range(0, 2) == 0);
      default: begin
        out_stall_i <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[15:1]};
      end
    endcase
  end

  initial begin
    int   r;
    int   k;
    int   len;
    int   pick;
    logic act;
    for (r = 0; r < MAP_N; r++) virgin_copy[r] = WORD_ONES;
    verdict_acc = VERD_NONE;
    errors = 0;
    n_sent = 0;
    n_checks = 0;
    n_loads = 0;
    burst_left = 1;
    steady = 1'b0;
    stall_mode = STALL_NONE;
    mode_left = 0;
    stall_pat = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (r = 0; r < ROWS; r++) begin
      issue_item(DIRECTED[r].act, DIRECTED[r].idx, DIRECTED[r].word,
                 DIRECTED[r].last, DIRECTED[r].typed, DIRECTED[r].verdict);
    end

    hot_idx[0] = '0;
    hot_idx[1] = '1;
    for (r = 2; r < HOT_N; r++) hot_idx[r] = IDX_W'($urandom_range(0, MAP_N-1));

    while (n_sent < ROWS + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        repeat ($urandom_range(0, 2)) begin
          issue_item(ACT_LOAD, hot_pick(), virgin_word(), 1'($urandom), 1'b0, VERD_NONE);
        end
        len = $urandom_range(1, 8);
        for (k = 0; k < len; k++) begin
          issue_item(ACT_CHECK, hot_pick(), coverage_word(), k == len - 1, 1'b0, VERD_NONE);
        end
      end else if (pick < 85) begin
        issue_item(1'($urandom), IDX_W'($urandom_range(0, MAP_N-1)),
                   {$urandom, $urandom}, 1'($urandom), 1'b0, VERD_NONE);
      end else begin
        len = $urandom_range(1, 6);
        for (k = 0; k < len; k++) begin
          act = 1'($urandom);
          issue_item(act, hot_pick(), (act == ACT_LOAD) ? virgin_word() : coverage_word(),
                     $urandom_range(0, 3) == 0, 1'b0, VERD_NONE);
        end
      end
    end
    in_valid_i <= 1'b0;

    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d items: %0d checks and %0d loads.", n_sent, n_checks, n_loads);
    $display("Verdicts seen: %0d nothing new, %0d new hit counts, %0d new bytes.",
             verdict_seen[0], verdict_seen[1], verdict_seen[2]);
    if (errors == 0) begin
      $display("[coverage_novelty_check_top] OK");
    end else begin
      $display("[coverage_novelty_check_top] ERROR");
    end
    $finish;
  end

endmodule
